/* design/pipr_pkg.sv */
// ----------------------------------------------------------------------------
// pipr_pkg
// Shared types, op codes and the microcode program of the point-in-polygon
// crossing-number core.
// ----------------------------------------------------------------------------
package pipr_pkg;

  localparam int MAX_VERTICES_DEF = 64;

  localparam int COORD_W = 16;
  localparam int VERT_W  = 2 * COORD_W;
  localparam int CNT_W   = 7;
  localparam int OP_W    = 2;

  // Item op codes; the fourth code is unused and changes nothing
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_TEST   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_CLEAR  = 4'd1,
    ST_APPEND = 4'd2,
    ST_TEST   = 4'd3,
    ST_READ   = 4'd4,
    ST_WAIT   = 4'd5,
    ST_CLOSE  = 4'd6,
    ST_DRAIN1 = 4'd7,
    ST_DRAIN2 = 4'd8,
    ST_EMIT   = 4'd9
  } step_t;

  typedef enum logic [2:0] {
    COND_NEXT,      // fall through
    COND_GOTO,      // always jump
    COND_DISPATCH,  // on accept jump by op, else hold
    COND_IF_LT2,    // jump when fewer than two vertices
    COND_LOOP,      // jump back until the last vertex is read
    COND_WAIT_OUT   // jump when the output register is free, else hold
  } cond_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  in_ready;
    logic  clr_verts;
    logic  append;
    logic  test_init;
    logic  rd_issue;
    logic  close_edge;
    logic  emit;
  } ctrl_word_t;

  typedef struct packed {
    logic            accept;
    logic [OP_W-1:0] op;
    logic            lt2;
    logic            ptr_last;
    logic            out_free;
  } seq_stat_t;

  function automatic ctrl_word_t cw(cond_t c, step_t t);
    ctrl_word_t w;
    w = '0;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // Microcode ROM
  function automatic ctrl_word_t ucode(step_t s);
    ctrl_word_t w;
    w = cw(COND_GOTO, ST_IDLE);
    case (s)
      ST_IDLE: begin
        w = cw(COND_DISPATCH, ST_IDLE);
        w.in_ready = 1'b1;
      end
      ST_CLEAR: begin
        w = cw(COND_GOTO, ST_EMIT);
        w.clr_verts = 1'b1;
      end
      ST_APPEND: begin
        w = cw(COND_GOTO, ST_EMIT);
        w.append = 1'b1;
      end
      ST_TEST: begin
        w = cw(COND_IF_LT2, ST_EMIT);
        w.test_init = 1'b1;
      end
      ST_READ: begin
        w = cw(COND_LOOP, ST_READ);
        w.rd_issue = 1'b1;
      end
      ST_WAIT:   w = cw(COND_NEXT, ST_IDLE);
      ST_CLOSE: begin
        w = cw(COND_NEXT, ST_IDLE);
        w.close_edge = 1'b1;
      end
      ST_DRAIN1: w = cw(COND_NEXT, ST_IDLE);
      ST_DRAIN2: w = cw(COND_NEXT, ST_IDLE);
      ST_EMIT: begin
        w = cw(COND_WAIT_OUT, ST_IDLE);
        w.emit = 1'b1;
      end
      default:   w = cw(COND_GOTO, ST_IDLE);
    endcase
    return w;
  endfunction

  // Entry step for each op code; the unused code goes straight to the result
  function automatic step_t dispatch(logic [OP_W-1:0] op);
    step_t s;
    case (op)
      OP_CLEAR:  s = ST_CLEAR;
      OP_APPEND: s = ST_APPEND;
      OP_TEST:   s = ST_TEST;
      default:   s = ST_EMIT;
    endcase
    return s;
  endfunction

endpackage

/* design/pipr_ram.sv */
// ----------------------------------------------------------------------------
// pipr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pipr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/pipr_seq.sv */
// ----------------------------------------------------------------------------
// pipr_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module pipr_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  pipr_pkg::seq_stat_t  stat,
  output pipr_pkg::ctrl_word_t ctrl
);
  import pipr_pkg::*;

  step_t      pc;
  step_t      pc_next;
  ctrl_word_t word;
  step_t      pc_inc;

  assign word   = ucode(pc);
  assign pc_inc = step_t'(pc + 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    pc_next = pc;
    case (word.cond)
      COND_NEXT:     pc_next = pc_inc;
      COND_GOTO:     pc_next = word.target;
      COND_DISPATCH: pc_next = stat.accept ? dispatch(stat.op) : pc;
      COND_IF_LT2:   pc_next = stat.lt2 ? word.target : pc_inc;
      COND_LOOP:     pc_next = stat.ptr_last ? pc_inc : word.target;
      COND_WAIT_OUT: pc_next = stat.out_free ? word.target : pc;
      default:       pc_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = word;
  end

endmodule

/* design/pipr_datapath.sv */
// ----------------------------------------------------------------------------
// pipr_datapath
// Vertex store, walk pointer, edge test pipeline, crossing counter and
// output register.
// ----------------------------------------------------------------------------
module pipr_datapath #(
  parameter int MAX_VERTICES = pipr_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pipr_pkg::ctrl_word_t          ctrl,
  output pipr_pkg::seq_stat_t           stat,
  input  logic                          s_tvalid,
  input  logic [pipr_pkg::OP_W-1:0]     s_tuser,
  input  logic [pipr_pkg::VERT_W-1:0]   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata
);
  import pipr_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic                 accept;
  logic                 out_free;
  logic [CW-1:0]        vertex_count;
  logic [AW-1:0]        ptr;
  logic [OP_W-1:0]      op_q;
  logic signed [15:0]   px;
  logic signed [15:0]   py;
  logic                 drop;
  logic                 full;
  logic                 ram_we;
  logic [VERT_W-1:0]    rd_data;
  logic                 rd_valid;
  logic                 first_pending;
  logic [VERT_W-1:0]    first_v;
  logic [VERT_W-1:0]    prev_v;

  // edge feed
  logic                 edge_en;
  logic [VERT_W-1:0]    b_v;
  logic signed [15:0]   x1, y1, x2, y2;

  // stage 1: differences and span test
  logic                 s1_valid, s1_between, s1_dpos;
  logic signed [16:0]   s1_pxd, s1_dy, s1_pyd, s1_d;
  // stage 2: products
  logic                 s2_valid, s2_between, s2_dpos;
  logic signed [33:0]   s2_lhs, s2_rhs;
  logic                 crossed;
  logic [CNT_W-1:0]     cnt;
  logic                 is_test;

  assign accept   = s_tvalid & ctrl.in_ready;
  assign out_free = ~m_tvalid | m_tready;
  assign full     = (vertex_count == CW'(MAX_VERTICES));
  assign ram_we   = ctrl.append & ~full;

  assign stat.accept   = accept;
  assign stat.op       = s_tuser;
  assign stat.lt2      = (vertex_count < CW'(2));
  assign stat.ptr_last = (CW'(ptr) == (vertex_count - CW'(1)));
  assign stat.out_free = out_free;

  pipr_ram #(
    .WIDTH (VERT_W),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(vertex_count)),
    .wdata ({py, px}),
    .re    (ctrl.rd_issue),
    .raddr (ptr),
    .rdata (rd_data)
  );

  // Latch the item and keep the vertex count
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      drop         <= 1'b0;
      op_q         <= OP_CLEAR;
    end else begin
      if (accept) begin
        drop <= 1'b0;
        op_q <= s_tuser;
      end
      if (ctrl.clr_verts) begin
        vertex_count <= '0;
      end
      if (ctrl.append) begin
        if (full) begin
          drop <= 1'b1;
        end else begin
          vertex_count <= vertex_count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px <= s_tdata[15:0];
      py <= s_tdata[31:16];
    end
  end

  // Walk pointer and read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr           <= '0;
      rd_valid      <= 1'b0;
      first_pending <= 1'b0;
    end else begin
      rd_valid <= ctrl.rd_issue;
      if (ctrl.test_init) begin
        ptr           <= '0;
        first_pending <= 1'b1;
      end else if (ctrl.rd_issue) begin
        ptr <= ptr + AW'(1);
      end
      if (rd_valid && first_pending) begin
        first_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      prev_v <= rd_data;
      if (first_pending) begin
        first_v <= rd_data;
      end
    end
  end

  // Edge from the previous vertex to the new one, or the closing edge
  assign edge_en = ctrl.close_edge | (rd_valid & ~first_pending);
  assign b_v     = ctrl.close_edge ? first_v : rd_data;
  assign x1      = prev_v[15:0];
  assign y1      = prev_v[31:16];
  assign x2      = b_v[15:0];
  assign y2      = b_v[31:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= edge_en;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_between <= ((x1 < px) && (px < x2)) || ((x1 > px) && (px > x2));
    s1_dpos    <= (x1 > x2);
    s1_pxd     <= 17'(px) - 17'(x2);
    s1_dy      <= 17'(y1) - 17'(y2);
    s1_pyd     <= 17'(py) - 17'(y2);
    s1_d       <= 17'(x1) - 17'(x2);
    s2_between <= s1_between;
    s2_dpos    <= s1_dpos;
    s2_lhs     <= s1_pxd * s1_dy;
    s2_rhs     <= s1_pyd * s1_d;
  end

  assign crossed = s2_valid & s2_between &
                   (s2_dpos ? (s2_lhs >= s2_rhs) : (s2_lhs <= s2_rhs));

  // Count wraps at 7 bits, the width of the reported count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.test_init) begin
      cnt <= '0;
    end else if (crossed) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // Output register
  assign is_test = (op_q == OP_TEST);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.emit && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && out_free) begin
      m_tdata <= {7'd0,
                  is_test ? cnt : CNT_W'(0),
                  is_test & ~cnt[0],
                  drop};
    end
  end

endmodule

/* design/point_in_polygon_ray_cast_core.sv */
// ----------------------------------------------------------------------------
// point_in_polygon_ray_cast_core
// Crossing-number point-in-polygon test on signed Q8.8 coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item per handshake. s_tuser carries the op
//   (clear vertices, append vertex, test point), s_tdata the x and y.
//   Output channel m_*: exactly one result item per input item, in order.
//   Flow: clear and append step straight on to the result. A test on n stored
//   vertices (n of two or more) walks them: the walk reads one vertex per
//   cycle from the single read port of the vertex store, then the closing
//   edge and the three-stage edge pipeline (differences, products, compare
//   and count) drain. With fewer than two vertices a test goes straight to
//   its result. One item is worked at a time.
//   Stall: the result sits in an output register, so the next item is taken
//   while an earlier result still waits; the sequencer then holds at its
//   result step until m_tready frees the register.
//   Reset: rst clears the vertex count, the sequencer and m_tvalid; the
//   vertex store itself is not cleared and needs no clearing pass.
//   An append to a full store is dropped and reported with status set.
// ----------------------------------------------------------------------------
module point_in_polygon_ray_cast_core #(
  parameter int MAX_VERTICES = pipr_pkg::MAX_VERTICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] coord_x, [31:16] coord_y
  input  logic [1:0]  s_tuser,   // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [0] status, [1] is_outside,
                                 // [8:2] crossing_count, [15:9] zero
);
  import pipr_pkg::*;

  ctrl_word_t ctrl;
  seq_stat_t  stat;

  // Ready only at the idle step of the program
  assign s_tready = ctrl.in_ready;

  pipr_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  pipr_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .stat     (stat),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
